>>> design/fifo_page_pool_directory_core_macros.svh
// Assertion helpers shared by the directory core.
// Both macros expect signals named clk and rst_n in the calling scope.
`ifndef FIFO_PAGE_POOL_DIRECTORY_CORE_MACROS_SVH
`define FIFO_PAGE_POOL_DIRECTORY_CORE_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define FPPD_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fppd: assertion failed");

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define FPPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fppd: assertion failed");

`endif

>>> design/fppd_pkg.sv
package fppd_pkg;

    localparam int POOL_DEPTH_DEFAULT = 8;
    localparam int KEY_W              = 24;
    localparam int LIMIT_W            = 4;
    localparam int OCC_W              = 4;

    typedef logic [LIMIT_W-1:0] limit_t;
    typedef logic [KEY_W-1:0]   key_t;

    localparam limit_t LIMIT_RESET = limit_t'(8);
    localparam logic [OCC_W-1:0] OCC_MAX = '1;

    typedef enum logic [1:0] {
        ACT_GET     = 2'd0,
        ACT_REFRESH = 2'd1,
        ACT_REMOVE  = 2'd2,
        ACT_LOOKUP  = 2'd3
    } action_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  table_id;
        logic [15:0] page_index;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic             evicted;
        logic [7:0]       evicted_table;
        logic [15:0]      evicted_page;
        logic [OCC_W-1:0] occupancy;
    } res_t;

    // Update command from the control logic to the key store.
    typedef struct packed {
        logic del_head;   // drop the oldest entry
        logic del_match;  // drop the matching entry
        logic app_en;     // append the request key at the newest position
    } upd_t;

endpackage

>>> design/fifo_page_pool_directory_core.sv
// Directory of a fully associative page pool with first-in-first-out
// replacement. Requests arrive as one word on req and are taken at a clock
// edge where start is high and busy is low; busy is always low, so a new
// request may be issued in every cycle. Each request yields exactly one
// result word on res, marked by res_valid for a single cycle. The request is
// registered at the edge that takes it. The key compare, eviction choice and
// compaction of the entry array are then resolved combinationally, and the
// result register loads at the next edge. One request per cycle is
// sustained; the parallel compare and shift over the entry row set that
// figure. The receiver cannot stall, so it must take every result word in
// the cycle it is shown. The pool_limit register is written through the
// cfg_valid/cfg_ready channel; cfg_ready drops while a request is being
// resolved. Reset empties the directory, clears any pending result and sets
// pool_limit to eight. Entry contents are not cleared; the resident count
// alone decides which entries are live.
module fifo_page_pool_directory_core #(
    parameter int POOL_DEPTH = fppd_pkg::POOL_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  fppd_pkg::req_t   req,
    output logic             res_valid,
    output fppd_pkg::res_t   res,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  fppd_pkg::limit_t cfg_data
);
    import fppd_pkg::*;

    `include "fifo_page_pool_directory_core_macros.svh"

    localparam int CW = $clog2(POOL_DEPTH + 1);

    logic          pend_reg;
    req_t          req_reg;
    limit_t        limit_reg;
    logic          res_valid_reg;
    res_t          res_reg;
    res_t          res_next;
    upd_t          upd;
    logic          hit;
    key_t          head_key;
    key_t          lookup_key;
    logic [CW-1:0] count;
    logic [CW-1:0] count_next;

    // The block never refuses a request.
    assign busy      = 1'b0;
    assign cfg_ready = ~pend_reg;
    assign lookup_key = {req_reg.table_id, req_reg.page_index};

    fppd_store #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .lookup_key (lookup_key),
        .upd        (upd),
        .hit        (hit),
        .head_key   (head_key),
        .count      (count),
        .count_next (count_next)
    );

    fppd_ctrl #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_ctrl (
        .pend       (pend_reg),
        .action     (req_reg.action),
        .hit        (hit),
        .limit      (limit_reg),
        .head_key   (head_key),
        .count      (count),
        .count_next (count_next),
        .upd        (upd),
        .res        (res_next)
    );

    // Request and result capture; the payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            req_reg <= req;
        if (pend_reg)
            res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            pend_reg      <= start && !busy;
            res_valid_reg <= pend_reg;
            if (cfg_valid && cfg_ready)
                limit_reg <= cfg_data;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Every accepted request produces its result word, through pend_reg and res_valid_reg.
    `FPPD_ASSERT_IMPLIES(a_result_follows, start && !busy, ##2 res_valid)
    // An eviction only happens on a get that missed.
    `FPPD_ASSERT_IMPLIES(a_evict_on_miss, res_valid && res.evicted, !res.hit)
    // Without an eviction the evicted key fields read as zero.
    `FPPD_ASSERT_IMPLIES(a_evict_zero, res_valid && !res.evicted,
        res.evicted_table == 8'd0 && res.evicted_page == 16'd0)
    // The count never exceeds the number of entries.
    `FPPD_ASSERT_NEXT(a_count_bound, pend_reg, count <= CW'(POOL_DEPTH))

endmodule

>>> design/fppd_store.sv
module fppd_store #(
    parameter int POOL_DEPTH = fppd_pkg::POOL_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fppd_pkg::key_t                  lookup_key,
    input  fppd_pkg::upd_t                  upd,
    output logic                            hit,
    output fppd_pkg::key_t                  head_key,
    output logic [$clog2(POOL_DEPTH+1)-1:0] count,
    output logic [$clog2(POOL_DEPTH+1)-1:0] count_next
);
    import fppd_pkg::*;

    localparam int CW = $clog2(POOL_DEPTH + 1);

    key_t            keys_reg  [POOL_DEPTH];
    key_t            keys_next [POOL_DEPTH];
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_del;
    logic [POOL_DEPTH-1:0] match;
    logic [POOL_DEPTH-1:0] from_pos;
    logic [POOL_DEPTH-1:0] shift;
    logic            del;

    // Keys are held oldest first; only entries below the count take part.
    always_comb
    begin
        for (int i = 0; i < POOL_DEPTH; i++)
        begin
            match[i] = (CW'(i) < count_reg) && (keys_reg[i] == lookup_key);
        end
        from_pos[0] = match[0];
        for (int i = 1; i < POOL_DEPTH; i++)
        begin
            from_pos[i] = from_pos[i-1] | match[i];
        end
        for (int i = 0; i < POOL_DEPTH; i++)
        begin
            shift[i] = upd.del_head | (upd.del_match & from_pos[i]);
        end
    end

    assign hit       = |match;
    assign head_key  = keys_reg[0];
    assign del       = upd.del_head | (upd.del_match & hit);
    assign count_del = count_reg - CW'(del);
    assign count_next = count_del + CW'(upd.app_en);
    assign count     = count_reg;

    // Each entry either takes the new key, closes the gap from its upper
    // neighbor, or keeps its value.
    for (genvar g = 0; g < POOL_DEPTH; g++)
    begin : g_entry
        if (g < POOL_DEPTH - 1)
        begin : g_mid
            always_comb
            begin
                if (upd.app_en && (CW'(g) == count_del))
                    keys_next[g] = lookup_key;
                else if (shift[g])
                    keys_next[g] = keys_reg[g+1];
                else
                    keys_next[g] = keys_reg[g];
            end
        end
        else
        begin : g_top
            always_comb
            begin
                if (upd.app_en && (CW'(g) == count_del))
                    keys_next[g] = lookup_key;
                else
                    keys_next[g] = keys_reg[g];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < POOL_DEPTH; i++)
        begin
            keys_reg[i] <= keys_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

>>> design/fppd_ctrl.sv
module fppd_ctrl #(
    parameter int POOL_DEPTH = fppd_pkg::POOL_DEPTH_DEFAULT
) (
    input  logic                            pend,
    input  fppd_pkg::action_t               action,
    input  logic                            hit,
    input  fppd_pkg::limit_t                limit,
    input  fppd_pkg::key_t                  head_key,
    input  logic [$clog2(POOL_DEPTH+1)-1:0] count,
    input  logic [$clog2(POOL_DEPTH+1)-1:0] count_next,
    output fppd_pkg::upd_t                  upd,
    output fppd_pkg::res_t                  res
);
    import fppd_pkg::*;

    localparam int CW   = $clog2(POOL_DEPTH + 1);
    localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;

    logic [CMPW-1:0] lim_ext;
    logic [CMPW-1:0] lim_eff;
    logic [CMPW-1:0] occ_ext;
    logic            at_limit;

    // A zero limit acts as one; a limit beyond the depth acts as the depth.
    always_comb
    begin
        lim_ext = (limit == '0) ? CMPW'(1) : CMPW'(limit);
        lim_eff = (lim_ext > CMPW'(POOL_DEPTH)) ? CMPW'(POOL_DEPTH) : lim_ext;
        at_limit = (CMPW'(count) >= lim_eff) && (count != '0);
    end

    always_comb
    begin
        upd = '0;
        if (pend)
        begin
            case (action)
                ACT_GET:
                begin
                    if (!hit)
                    begin
                        upd.app_en   = 1'b1;
                        upd.del_head = at_limit;
                    end
                end
                ACT_REFRESH:
                begin
                    upd.del_match = hit;
                    upd.app_en    = hit;
                end
                ACT_REMOVE:
                begin
                    upd.del_match = hit;
                end
                default:
                begin
                    upd = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        occ_ext           = CMPW'(count_next);
        res.hit           = hit;
        res.evicted       = upd.del_head;
        res.evicted_table = upd.del_head ? head_key[23:16] : 8'd0;
        res.evicted_page  = upd.del_head ? head_key[15:0] : 16'd0;
        res.occupancy     = (occ_ext > CMPW'(OCC_MAX)) ? OCC_MAX : occ_ext[OCC_W-1:0];
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import fppd_pkg::*;

    localparam int POOL_DEPTH  = POOL_DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_ITEMS = 100;
    localparam int KEY_POOL = 12;
    // Spare cycles at the end catch any stray result word.
    localparam int DRAIN_CYCLES = 8;

    logic   clk;
    logic   rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    req_t   req = '0;
    logic   res_valid;
    res_t   res;
    logic   cfg_valid = 1'b0;
    logic   cfg_ready;
    limit_t cfg_data = '0;

    fifo_page_pool_directory_core #(
        .POOL_DEPTH(POOL_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .res_valid(res_valid),
        .res      (res),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // Request words waiting for the driver, and result words the directory
    // still owes us, oldest first.
    req_t request_backlog[$];
    res_t due_results[$];

    // Shadow copy of the directory: resident keys oldest first, the number
    // of live entries and the pool_limit register as last written.
    key_t   dir_keys[POOL_DEPTH];
    int     dir_count;
    limit_t limit_copy;

    int  error_count = 0;
    int  items_total = 0;
    int  results_seen;
    int  hits_seen;
    int  evictions_seen;
    int  limit_writes = 0;
    int  cycle_count = 0;
    logic word_taken;

    // Driver pacing: a burst of back-to-back request words, then a gap.
    int burst_left = 1;
    int gap_left = 0;

    // Keys that the random part revisits so that hits, refreshes and
    // removes of resident pages happen often.
    logic [7:0]  pool_tables[KEY_POOL];
    logic [15:0] pool_pages[KEY_POOL];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Remove the entry at position pos and close the gap behind it.
    task automatic drop_entry(input int pos);
        int i;
        for (i = pos; i + 1 < dir_count; i++)
            dir_keys[i] = dir_keys[i + 1];
        if (dir_count > 0)
            dir_count--;
    endtask

    // Apply one request to the shadow directory and build the result word
    // it should produce.
    task automatic directory_access(input req_t rq, output res_t rs);
        key_t key;
        int   pos;
        int   lim;
        int   i;
        key = {rq.table_id, rq.page_index};
        pos = -1;
        for (i = 0; i < dir_count; i++)
            if (pos < 0 && dir_keys[i] == key)
                pos = i;
        // A limit of zero behaves as one, and a limit past the array depth
        // is capped at the depth.
        lim = (limit_copy == '0) ? 1 : int'(limit_copy);
        if (lim > POOL_DEPTH)
            lim = POOL_DEPTH;
        rs = '0;
        rs.hit = (pos >= 0);
        case (rq.action)
            ACT_GET:
            begin
                if (pos < 0)
                begin
                    // Only the single oldest entry goes, even when the limit
                    // was lowered below the current occupancy.
                    if (dir_count >= lim && dir_count > 0)
                    begin
                        rs.evicted       = 1'b1;
                        rs.evicted_table = dir_keys[0][23:16];
                        rs.evicted_page  = dir_keys[0][15:0];
                        drop_entry(0);
                    end
                    if (dir_count < POOL_DEPTH)
                    begin
                        dir_keys[dir_count] = key;
                        dir_count++;
                    end
                end
            end
            ACT_REFRESH:
            begin
                // A refresh moves a resident key to the newest position.
                if (pos >= 0)
                begin
                    drop_entry(pos);
                    dir_keys[dir_count] = key;
                    dir_count++;
                end
            end
            ACT_REMOVE:
            begin
                if (pos >= 0)
                    drop_entry(pos);
            end
            default:
            begin
                // The spare action only reports whether the key is resident.
            end
        endcase
        rs.occupancy = (dir_count > 15) ? OCC_W'(15) : OCC_W'(dir_count);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // Monitor and predictor. Everything here is sampled at the rising edge,
    // while the testbench only moves inputs at the falling edge. The result
    // word is checked first, then the shadow register and directory are
    // updated from whatever handshake completes at this edge.
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        res_t next_result;
        if (!rst_n)
        begin
            word_taken     <= 1'b0;
            results_seen   <= 0;
            hits_seen      <= 0;
            evictions_seen <= 0;
            dir_count       = 0;
            limit_copy      = LIMIT_RESET;
            for (int i = 0; i < POOL_DEPTH; i++)
                dir_keys[i] = '0;
        end
        else
        begin
            if (res_valid)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result word with no request outstanding");
                    error_count++;
                end
                else
                begin
                    want = due_results[0];
                    due_results.delete(0);
                    check_field("hit", want.hit, res.hit);
                    check_field("evicted", want.evicted, res.evicted);
                    check_field("evicted_table", want.evicted_table, res.evicted_table);
                    check_field("evicted_page", want.evicted_page, res.evicted_page);
                    check_field("occupancy", want.occupancy, res.occupancy);
                    hits_seen      <= hits_seen + want.hit;
                    evictions_seen <= evictions_seen + want.evicted;
                end
                results_seen <= results_seen + 1;
            end
            if (cfg_valid && cfg_ready)
                limit_copy = cfg_data;
            word_taken <= start && !busy;
            if (start && !busy)
            begin
                directory_access(req, next_result);
                due_results.insert(due_results.size(), next_result);
            end
        end
    end

    // Driver. A word on req stays put until the edge that takes it; after
    // that the next word from the backlog goes out unless a gap is due.
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || word_taken)
        begin
            if (gap_left != 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (request_backlog.size() != 0)
            begin
                start <= 1'b1;
                req   <= request_backlog[0];
                request_backlog.delete(0);
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    // Some bursts run straight into the next one.
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic queue_request(input action_t act, input logic [7:0] tbl,
                                 input logic [15:0] pg);
        req_t word;
        word.action     = act;
        word.table_id   = tbl;
        word.page_index = pg;
        request_backlog.insert(request_backlog.size(), word);
        items_total++;
    endtask

    // Returns at a falling edge once every queued request has produced its
    // result word, so the directory is idle.
    task automatic wait_idle();
        @(negedge clk);
        while (results_seen != items_total)
            @(negedge clk);
    endtask

    // pool_limit may only change while the directory is idle.
    task automatic write_limit(input limit_t value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        limit_writes++;
    endtask

    // Mostly revisits a small set of keys, with fresh full-range keys mixed
    // in so that every key bit toggles.
    task automatic queue_random_phase(input int count);
        int      pick;
        int      slot;
        action_t act;
        for (int i = 0; i < KEY_POOL; i++)
        begin
            pool_tables[i] = 8'($urandom_range(0, 255));
            pool_pages[i]  = 16'($urandom_range(0, 65535));
        end
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                act = ACT_GET;
            else if (pick < 70)
                act = ACT_REFRESH;
            else if (pick < 88)
                act = ACT_REMOVE;
            else
                act = ACT_LOOKUP;
            if ($urandom_range(0, 3) != 0)
            begin
                slot = $urandom_range(0, KEY_POOL - 1);
                queue_request(act, pool_tables[slot], pool_pages[slot]);
            end
            else
                queue_request(act, 8'($urandom_range(0, 255)),
                              16'($urandom_range(0, 65535)));
        end
    endtask

    initial
    begin
        limit_t extremes[4];
        extremes[0] = limit_t'(1);
        extremes[1] = limit_t'(8);
        extremes[2] = limit_t'(0);
        extremes[3] = limit_t'(15);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset limit of eight: fill the pool with
        // extreme keys, then hit, evict, refresh, remove and look up.
        queue_request(ACT_GET, 8'h00, 16'h0000);
        queue_request(ACT_GET, 8'hFF, 16'hFFFF);
        queue_request(ACT_GET, 8'hAA, 16'h5555);
        queue_request(ACT_GET, 8'h55, 16'hAAAA);
        queue_request(ACT_GET, 8'h01, 16'h0001);
        queue_request(ACT_GET, 8'h02, 16'h0002);
        queue_request(ACT_GET, 8'h03, 16'h0003);
        queue_request(ACT_GET, 8'h04, 16'h0004);
        queue_request(ACT_GET, 8'h00, 16'h0000);
        queue_request(ACT_GET, 8'h09, 16'h0009);
        queue_request(ACT_REFRESH, 8'hFF, 16'hFFFF);
        queue_request(ACT_REFRESH, 8'h07, 16'h0007);
        queue_request(ACT_REMOVE, 8'hAA, 16'h5555);
        queue_request(ACT_REMOVE, 8'hAA, 16'h5555);
        queue_request(ACT_LOOKUP, 8'h09, 16'h0009);
        queue_request(ACT_LOOKUP, 8'h08, 16'h0008);

        // Limit dropped below the current occupancy: each missing get pushes
        // out only the oldest entry, so occupancy stays where it was.
        write_limit(limit_t'(2));
        queue_request(ACT_GET, 8'h0A, 16'h000A);
        queue_request(ACT_GET, 8'h0B, 16'h000B);
        queue_request(ACT_REMOVE, 8'h09, 16'h0009);

        // A limit of zero behaves as a limit of one.
        write_limit(limit_t'(0));
        queue_request(ACT_GET, 8'h0C, 16'h000C);
        queue_request(ACT_GET, 8'h0D, 16'h000D);

        // A limit past the depth is capped at the depth.
        write_limit(limit_t'(15));
        queue_request(ACT_GET, 8'h0E, 16'h000E);
        queue_request(ACT_GET, 8'h0F, 16'h000F);

        // Random phases, each under its own limit: the extremes first, then
        // arbitrary values over the whole register range.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_limit((p < 4) ? extremes[p] : limit_t'($urandom_range(0, 15)));
            queue_random_phase(PHASE_ITEMS);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (due_results.size() != 0)
            $error("%0d result words never arrived", due_results.size());
        $display("Checked %0d requests under %0d pool_limit writes: %0d hits, %0d evictions.",
                 results_seen, limit_writes, hits_seen, evictions_seen);
        if (error_count == 0 && due_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
